// ----- design/avr_pkg.sv -----
`timescale 1ns / 1ps

package avr_pkg;

    localparam int TempW    = 15;
    localparam int HumidW   = 14;
    localparam int PressW   = 17;
    localparam int VerdictW = 3;
    localparam int DataW    = 32;

    // pressure history, 1 to 16 entries
    localparam int HistDepth = 5;
    localparam int CountW    = $clog2(HistDepth + 1);
    localparam int SlotW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;

    // serial word: holds n*p + n*limit with room for a sign bit
    localparam int SerW = PressW + CountW + 2;
    localparam int BitW = $clog2(SerW);
    localparam int AccW = CountW + 1;

    localparam int RegNum   = 8;
    localparam int RegIdxW  = $clog2(RegNum);
    localparam int AddrW    = RegIdxW + 2;

    localparam logic [TempW-1:0]  TempMinRst  = TempW'(-1000);
    localparam logic [TempW-1:0]  TempMaxRst  = TempW'(4000);
    localparam logic [HumidW-1:0] HumidMinRst = HumidW'(0);
    localparam logic [HumidW-1:0] HumidMaxRst = HumidW'(10000);
    localparam logic [PressW-1:0] PressMinRst = PressW'(85000);
    localparam logic [PressW-1:0] PressMaxRst = PressW'(110000);
    localparam logic [PressW-1:0] JumpLimRst  = PressW'(150);
    localparam logic [PressW-1:0] DevLimRst   = PressW'(150);

    typedef enum logic [VerdictW-1:0] {
        V_OK      = 3'd0,
        V_MISSING = 3'd1,
        V_TEMP    = 3'd2,
        V_HUMID   = 3'd3,
        V_PRANGE  = 3'd4,
        V_JUMP    = 3'd5,
        V_DEV     = 3'd6
    } t_verdict;

    typedef enum logic [RegIdxW-1:0] {
        REG_TEMP_MIN  = 3'd0,
        REG_TEMP_MAX  = 3'd1,
        REG_HUMID_MIN = 3'd2,
        REG_HUMID_MAX = 3'd3,
        REG_PRESS_MIN = 3'd4,
        REG_PRESS_MAX = 3'd5,
        REG_JUMP_LIM  = 3'd6,
        REG_DEV_LIM   = 3'd7
    } t_reg_idx;

    // temperature fields are two's complement
    typedef struct packed {
        logic [TempW-1:0]  temp_min;
        logic [TempW-1:0]  temp_max;
        logic [HumidW-1:0] humid_min;
        logic [HumidW-1:0] humid_max;
        logic [PressW-1:0] press_min;
        logic [PressW-1:0] press_max;
        logic [PressW-1:0] jump_limit;
        logic [PressW-1:0] deviation_limit;
    } t_cfg;

    typedef struct packed {
        logic [TempW-1:0]  temperature;
        logic [HumidW-1:0] humidity;
        logic [PressW-1:0] pressure;
        logic [PressW-1:0] last_pressure;
        t_cfg              cfg;
    } t_opnd;

    typedef logic [HistDepth-1:0][PressW-1:0] t_hist;

    typedef struct packed {
        logic temp_fail;
        logic humid_fail;
        logic press_fail;
        logic jump_fail;
        logic dev_fail;
    } t_flags;

endpackage

// ----- design/avr_check.sv -----
`timescale 1ns / 1ps

// Bit-serial window, jump and mean checks. All operands are loaded into
// SerW-bit shift registers and leave LSB first, one bit per cycle.
module avr_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  avr_pkg::t_opnd             i_opnd,
    input  avr_pkg::t_hist             i_hist,
    input  logic [avr_pkg::CountW-1:0] i_count,
    output logic                       o_done,
    output avr_pkg::t_flags            o_flags
);

    localparam int OpT    = 0;
    localparam int OpTMin = 1;
    localparam int OpTMax = 2;
    localparam int OpH    = 3;
    localparam int OpHMin = 4;
    localparam int OpHMax = 5;
    localparam int OpP    = 6;
    localparam int OpPMin = 7;
    localparam int OpPMax = 8;
    localparam int OpLast = 9;
    localparam int OpJl   = 10;
    localparam int OpDl   = 11;
    localparam int NumOps = 12;

    localparam int CmpTLo = 0;
    localparam int CmpTHi = 1;
    localparam int CmpHLo = 2;
    localparam int CmpHHi = 3;
    localparam int CmpPLo = 4;
    localparam int CmpPHi = 5;
    localparam int CmpJUp = 6;
    localparam int CmpJDn = 7;
    localparam int CmpDUp = 8;
    localparam int CmpDDn = 9;
    localparam int NumCmp = 10;

    localparam int SerW = avr_pkg::SerW;
    localparam int TempW = avr_pkg::TempW;

    logic [SerW-1:0]            r_sr  [NumOps];
    logic [SerW-1:0]            r_hsr [avr_pkg::HistDepth];
    logic                       r_run;
    logic                       r_done;
    logic [avr_pkg::BitW-1:0]   r_bit;
    logic                       r_ca, r_cb, r_c1, r_c2;
    logic [avr_pkg::CountW-1:0] r_cx, r_cl, r_cs;
    logic [NumCmp-1:0]          r_lt;
    avr_pkg::t_flags            r_flags;

    logic [NumCmp-1:0]          n_lt;
    logic [NumCmp-1:0]          cmp_a, cmp_b;
    logic [avr_pkg::AccW-1:0]   acc_x, acc_l, acc_s;
    logic                       a_bit, b_bit, x_bit, l_bit, s_bit, t1_bit, t2_bit;
    logic                       msb;
    logic                       t_b, tmin_b, tmax_b, h_b, hmin_b, hmax_b;
    logic                       p_b, pmin_b, pmax_b, last_b, jl_b, dl_b;

    always_comb begin
        t_b    = r_sr[OpT][0];
        tmin_b = r_sr[OpTMin][0];
        tmax_b = r_sr[OpTMax][0];
        h_b    = r_sr[OpH][0];
        hmin_b = r_sr[OpHMin][0];
        hmax_b = r_sr[OpHMax][0];
        p_b    = r_sr[OpP][0];
        pmin_b = r_sr[OpPMin][0];
        pmax_b = r_sr[OpPMax][0];
        last_b = r_sr[OpLast][0];
        jl_b   = r_sr[OpJl][0];
        dl_b   = r_sr[OpDl][0];
        msb    = (r_bit == avr_pkg::BitW'(SerW - 1));

        // last + jump_limit and p + jump_limit
        a_bit = last_b ^ jl_b ^ r_ca;
        b_bit = p_b ^ jl_b ^ r_cb;

        // n*p and n*deviation_limit: column adds of n copies of one bit
        acc_x = avr_pkg::AccW'(r_cx) + (p_b  ? avr_pkg::AccW'(i_count) : '0);
        acc_l = avr_pkg::AccW'(r_cl) + (dl_b ? avr_pkg::AccW'(i_count) : '0);
        x_bit = acc_x[0];
        l_bit = acc_l[0];

        // history sum over the n written entries
        acc_s = avr_pkg::AccW'(r_cs);
        for (int k = 0; k < avr_pkg::HistDepth; k++) begin
            if (avr_pkg::CountW'(k) < i_count) begin
                acc_s = acc_s + avr_pkg::AccW'(r_hsr[k][0]);
            end
        end
        s_bit = acc_s[0];

        t1_bit = s_bit ^ l_bit ^ r_c1;   // sum + n*limit
        t2_bit = x_bit ^ l_bit ^ r_c2;   // n*p + n*limit

        // each comparator tracks a < b
        cmp_a[CmpTLo] = t_b;     cmp_b[CmpTLo] = tmin_b;
        cmp_a[CmpTHi] = tmax_b;  cmp_b[CmpTHi] = t_b;
        cmp_a[CmpHLo] = h_b;     cmp_b[CmpHLo] = hmin_b;
        cmp_a[CmpHHi] = hmax_b;  cmp_b[CmpHHi] = h_b;
        cmp_a[CmpPLo] = p_b;     cmp_b[CmpPLo] = pmin_b;
        cmp_a[CmpPHi] = pmax_b;  cmp_b[CmpPHi] = p_b;
        cmp_a[CmpJUp] = a_bit;   cmp_b[CmpJUp] = p_b;
        cmp_a[CmpJDn] = b_bit;   cmp_b[CmpJDn] = last_b;
        cmp_a[CmpDUp] = t1_bit;  cmp_b[CmpDUp] = x_bit;
        cmp_a[CmpDDn] = t2_bit;  cmp_b[CmpDDn] = s_bit;

        // LSB first: the highest differing bit decides; sign bit reversed
        for (int j = 0; j < NumCmp; j++) begin
            if (cmp_a[j] != cmp_b[j]) begin
                n_lt[j] = msb ? cmp_a[j] : cmp_b[j];
            end else begin
                n_lt[j] = r_lt[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_run && !i_start && msb;
            if (i_start) begin
                r_run <= 1'b1;
                r_bit <= '0;
                r_ca  <= 1'b0;
                r_cb  <= 1'b0;
                r_c1  <= 1'b0;
                r_c2  <= 1'b0;
                r_cx  <= '0;
                r_cl  <= '0;
                r_cs  <= '0;
                r_lt  <= '0;
                r_sr[OpT]    <= {{(SerW - TempW){i_opnd.temperature[TempW-1]}},
                                 i_opnd.temperature};
                r_sr[OpTMin] <= {{(SerW - TempW){i_opnd.cfg.temp_min[TempW-1]}},
                                 i_opnd.cfg.temp_min};
                r_sr[OpTMax] <= {{(SerW - TempW){i_opnd.cfg.temp_max[TempW-1]}},
                                 i_opnd.cfg.temp_max};
                r_sr[OpH]    <= SerW'(i_opnd.humidity);
                r_sr[OpHMin] <= SerW'(i_opnd.cfg.humid_min);
                r_sr[OpHMax] <= SerW'(i_opnd.cfg.humid_max);
                r_sr[OpP]    <= SerW'(i_opnd.pressure);
                r_sr[OpPMin] <= SerW'(i_opnd.cfg.press_min);
                r_sr[OpPMax] <= SerW'(i_opnd.cfg.press_max);
                r_sr[OpLast] <= SerW'(i_opnd.last_pressure);
                r_sr[OpJl]   <= SerW'(i_opnd.cfg.jump_limit);
                r_sr[OpDl]   <= SerW'(i_opnd.cfg.deviation_limit);
                for (int k = 0; k < avr_pkg::HistDepth; k++) begin
                    r_hsr[k] <= SerW'(i_hist[k]);
                end
            end else if (r_run) begin
                for (int j = 0; j < NumOps; j++) begin
                    r_sr[j] <= r_sr[j] >> 1;
                end
                for (int k = 0; k < avr_pkg::HistDepth; k++) begin
                    r_hsr[k] <= r_hsr[k] >> 1;
                end
                r_ca <= (last_b & jl_b) | (last_b & r_ca) | (jl_b & r_ca);
                r_cb <= (p_b & jl_b) | (p_b & r_cb) | (jl_b & r_cb);
                r_c1 <= (s_bit & l_bit) | (s_bit & r_c1) | (l_bit & r_c1);
                r_c2 <= (x_bit & l_bit) | (x_bit & r_c2) | (l_bit & r_c2);
                r_cx <= acc_x[avr_pkg::AccW-1:1];
                r_cl <= acc_l[avr_pkg::AccW-1:1];
                r_cs <= acc_s[avr_pkg::AccW-1:1];
                r_lt <= n_lt;
                r_bit <= r_bit + 1'b1;
                if (msb) begin
                    r_run  <= 1'b0;
                    r_flags.temp_fail  <= n_lt[CmpTLo] | n_lt[CmpTHi];
                    r_flags.humid_fail <= n_lt[CmpHLo] | n_lt[CmpHHi];
                    r_flags.press_fail <= n_lt[CmpPLo] | n_lt[CmpPHi];
                    r_flags.jump_fail  <= n_lt[CmpJUp] | n_lt[CmpJDn];
                    r_flags.dev_fail   <= n_lt[CmpDUp] | n_lt[CmpDDn];
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_flags = r_flags;

endmodule

// ----- design/ambient_reading_validator.sv -----
`timescale 1ns / 1ps

// Ambient reading validator.
// Input channel: i_in_valid / o_in_stall with temperature, humidity,
// pressure and the missing flag. Output channel: o_out_valid / i_out_stall
// with accepted and a 3-bit verdict, one result per reading.
// Configuration: APB-style port, eight 32-bit registers at 4*index,
// pready tied high; write only while no reading is in flight.
// Timing: all checks run bit-serially through one SerW-bit pass; the input
// transfer is registered into r_start, which starts the pass, and its done
// pulse moves ST_RUN to ST_DONE, where the result is loaded for o_out_valid.
// One reading is handled at a time; o_in_stall is high from the transfer
// until the result is loaded, so no new reading is taken before then.
// A stalled receiver holds the result in the output register; a finished
// verdict waits in ST_DONE until the register frees, and only then is the
// history updated and the next reading taken.
// Reset (synchronous, active low) restores the register defaults, clears
// the last-pressure and history bookkeeping and empties both channels.
module ambient_reading_validator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [avr_pkg::AddrW-1:0]    paddr,
    input  logic [avr_pkg::DataW-1:0]    pwdata,
    output logic [avr_pkg::DataW-1:0]    prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [avr_pkg::TempW-1:0] i_temperature,
    input  logic [avr_pkg::HumidW-1:0]   i_humidity,
    input  logic [avr_pkg::PressW-1:0]   i_pressure,
    input  logic                         i_missing,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_accepted,
    output logic [avr_pkg::VerdictW-1:0] o_verdict
);

    localparam int TempW  = avr_pkg::TempW;
    localparam int HumidW = avr_pkg::HumidW;
    localparam int PressW = avr_pkg::PressW;
    localparam int DataW  = avr_pkg::DataW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                     r_state;
    avr_pkg::t_cfg              r_cfg;
    logic                       r_start;
    logic [TempW-1:0]           r_temp;
    logic [HumidW-1:0]          r_humid;
    logic [PressW-1:0]          r_press;
    logic                       r_missing;
    logic [PressW-1:0]          r_last;
    logic                       r_have_last;
    avr_pkg::t_hist             r_hist;
    logic [avr_pkg::SlotW-1:0]  r_slot;
    logic                       r_full;
    logic                       r_out_valid;
    logic                       r_accepted;
    avr_pkg::t_verdict          r_verdict;

    logic                       in_xfer, out_xfer, out_free, cfg_wr;
    avr_pkg::t_reg_idx          reg_idx;
    logic [avr_pkg::CountW-1:0] hist_count;
    avr_pkg::t_opnd             opnd;
    logic                       chk_done;
    avr_pkg::t_flags            chk_flags;
    avr_pkg::t_verdict          n_verdict;

    assign in_xfer  = i_in_valid && (r_state == ST_IDLE);
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite;
    assign reg_idx  = avr_pkg::t_reg_idx'(paddr[avr_pkg::AddrW-1:2]);

    assign hist_count = r_full ? avr_pkg::CountW'(avr_pkg::HistDepth)
                               : avr_pkg::CountW'(r_slot);

    always_comb begin
        opnd.temperature   = r_temp;
        opnd.humidity      = r_humid;
        opnd.pressure      = r_press;
        opnd.last_pressure = r_last;
        opnd.cfg           = r_cfg;
    end

    avr_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_opnd  (opnd),
        .i_hist  (r_hist),
        .i_count (hist_count),
        .o_done  (chk_done),
        .o_flags (chk_flags)
    );

    // first failing check wins; the first good reading skips jump and mean
    always_comb begin
        priority if (r_missing) begin
            n_verdict = avr_pkg::V_MISSING;
        end else if (chk_flags.temp_fail) begin
            n_verdict = avr_pkg::V_TEMP;
        end else if (chk_flags.humid_fail) begin
            n_verdict = avr_pkg::V_HUMID;
        end else if (chk_flags.press_fail) begin
            n_verdict = avr_pkg::V_PRANGE;
        end else if (!r_have_last) begin
            n_verdict = avr_pkg::V_OK;
        end else if (chk_flags.jump_fail) begin
            n_verdict = avr_pkg::V_JUMP;
        end else if (chk_flags.dev_fail && (hist_count != '0)) begin
            n_verdict = avr_pkg::V_DEV;
        end else begin
            n_verdict = avr_pkg::V_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_have_last <= 1'b0;
            r_last      <= '0;
            r_slot      <= '0;
            r_full      <= 1'b0;
        end else begin
            r_start <= in_xfer;
            // in ST_DONE a free output register is reloaded below
            if (out_xfer && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_temp    <= i_temperature;
                        r_humid   <= i_humidity;
                        r_press   <= i_pressure;
                        r_missing <= i_missing;
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (chk_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_accepted  <= (n_verdict == avr_pkg::V_OK);
                        r_verdict   <= n_verdict;
                        if (n_verdict == avr_pkg::V_OK) begin
                            r_last         <= r_press;
                            r_have_last    <= 1'b1;
                            r_hist[r_slot] <= r_press;
                            if (r_slot == avr_pkg::SlotW'(avr_pkg::HistDepth - 1)) begin
                                r_slot <= '0;
                                r_full <= 1'b1;
                            end else begin
                                r_slot <= r_slot + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_min        <= avr_pkg::TempMinRst;
            r_cfg.temp_max        <= avr_pkg::TempMaxRst;
            r_cfg.humid_min       <= avr_pkg::HumidMinRst;
            r_cfg.humid_max       <= avr_pkg::HumidMaxRst;
            r_cfg.press_min       <= avr_pkg::PressMinRst;
            r_cfg.press_max       <= avr_pkg::PressMaxRst;
            r_cfg.jump_limit      <= avr_pkg::JumpLimRst;
            r_cfg.deviation_limit <= avr_pkg::DevLimRst;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                avr_pkg::REG_TEMP_MIN:  r_cfg.temp_min        <= pwdata[TempW-1:0];
                avr_pkg::REG_TEMP_MAX:  r_cfg.temp_max        <= pwdata[TempW-1:0];
                avr_pkg::REG_HUMID_MIN: r_cfg.humid_min       <= pwdata[HumidW-1:0];
                avr_pkg::REG_HUMID_MAX: r_cfg.humid_max       <= pwdata[HumidW-1:0];
                avr_pkg::REG_PRESS_MIN: r_cfg.press_min       <= pwdata[PressW-1:0];
                avr_pkg::REG_PRESS_MAX: r_cfg.press_max       <= pwdata[PressW-1:0];
                avr_pkg::REG_JUMP_LIM:  r_cfg.jump_limit      <= pwdata[PressW-1:0];
                avr_pkg::REG_DEV_LIM:   r_cfg.deviation_limit <= pwdata[PressW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            avr_pkg::REG_TEMP_MIN:
                prdata = {{(DataW - TempW){r_cfg.temp_min[TempW-1]}}, r_cfg.temp_min};
            avr_pkg::REG_TEMP_MAX:
                prdata = {{(DataW - TempW){r_cfg.temp_max[TempW-1]}}, r_cfg.temp_max};
            avr_pkg::REG_HUMID_MIN: prdata = DataW'(r_cfg.humid_min);
            avr_pkg::REG_HUMID_MAX: prdata = DataW'(r_cfg.humid_max);
            avr_pkg::REG_PRESS_MIN: prdata = DataW'(r_cfg.press_min);
            avr_pkg::REG_PRESS_MAX: prdata = DataW'(r_cfg.press_max);
            avr_pkg::REG_JUMP_LIM:  prdata = DataW'(r_cfg.jump_limit);
            avr_pkg::REG_DEV_LIM:   prdata = DataW'(r_cfg.deviation_limit);
            default:                prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_verdict   = r_verdict;

    // one reading in flight: a transfer always closes the input
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while a reading is in flight");

    a_verdict_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accepted == (o_verdict == avr_pkg::V_OK)))
        else $error("accepted flag disagrees with verdict");

    a_empty_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_last |-> ((r_slot == '0) && !r_full))
        else $error("history advanced without an accepted reading");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_done |-> (r_state == ST_RUN))
        else $error("check pass finished outside of a run");

endmodule
